// ===== src/paged_memory_with_frame_allocator_top_assert.svh =====
// Assertion macros shared by the checker of the paged memory block.
`ifndef PAGED_MEMORY_WITH_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define PAGED_MEMORY_WITH_FRAME_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, ignored while in reset.
`define PMFA_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("paged memory: implication failed");

// Next-cycle implication, ignored while in reset.
`define PMFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("paged memory: next-cycle check failed");

// Condition that must hold in the cycle after a reset cycle.
`define PMFA_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("paged memory: post-reset check failed");

`endif

// ===== src/pmfa_pkg.sv =====
// Shared constants, codes and types of the paged memory block.
package pmfa_pkg;

  localparam int PAGE_BYTES      = 256;
  localparam int PAGES_PER_SPACE = 16;
  localparam int FRAME_COUNT     = 8;
  localparam int SPACE_COUNT     = 4;

  localparam int ENTRY_COUNT = SPACE_COUNT * PAGES_PER_SPACE;
  localparam int BYTE_COUNT  = FRAME_COUNT * PAGE_BYTES;
  localparam int ADDR_LIMIT  = PAGES_PER_SPACE * PAGE_BYTES;

  localparam int OFFS_W  = $clog2(PAGE_BYTES);
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int ENTRY_W = $clog2(ENTRY_COUNT);
  localparam int BYTE_W  = $clog2(BYTE_COUNT);

  localparam int REQ_W    = 2;
  localparam int SPACE_W  = 2;
  localparam int VPAGE_W  = 8;
  localparam int VADDR_W  = 16;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 3;

  typedef enum logic [REQ_W-1:0] {
    OP_MAP, OP_UNMAP, OP_READ, OP_WRITE
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK, ST_RANGE, ST_NOT_MAPPED, ST_INCONSISTENT, ST_EXISTS, ST_FULL, ST_NOT_WRITABLE
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE, BK_DECIDE, BK_ZERO, BK_FRAME_RD
  } bk_state_t;

  // Classified request as it travels from front to back.
  typedef struct packed {
    op_t                op;
    logic               range_err;
    logic [ENTRY_W-1:0] entry;
    logic [OFFS_W-1:0]  offset;
    logic               writable;
    logic [DATA_W-1:0]  data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  // Page table word kept in memory; the mapped bit lives in flops.
  typedef struct packed {
    logic               can_write;
    logic [FRAME_W-1:0] frame;
  } entry_t;

endpackage

// ===== src/pmfa_if.sv =====
// Request and response channel interfaces of the paged memory block.
interface pmfa_req_if;
  logic                          valid;
  logic                          ready;
  logic [pmfa_pkg::REQ_W-1:0]    req_type;
  logic [pmfa_pkg::SPACE_W-1:0]  space_id;
  logic [pmfa_pkg::VPAGE_W-1:0]  page_num;
  logic [pmfa_pkg::VADDR_W-1:0]  byte_addr;
  logic                          page_writable;
  logic [pmfa_pkg::DATA_W-1:0]   write_data;

  modport source(output valid, req_type, space_id, page_num, byte_addr,
                 page_writable, write_data, input ready);
  modport sink(input valid, req_type, space_id, page_num, byte_addr,
               page_writable, write_data, output ready);
endinterface

interface pmfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pmfa_pkg::STATUS_W-1:0] status;
  logic [pmfa_pkg::DATA_W-1:0]   read_data;

  modport source(output valid, status, read_data, input ready);
  modport sink(input valid, status, read_data, output ready);
endinterface

// ===== src/paged_memory_with_frame_allocator_top.sv =====
// Top level of the paged memory with frame allocator.
// Paged byte memory for four address spaces of sixteen 256-byte pages, backed by
// eight physical frames. Every request gives exactly one response with a status
// and, for a good read, the byte. A front end range-checks each request and
// forms its page table index; a two-deep queue holds classified requests so new
// requests are taken while the back end works or a response waits. The back end
// handles one request at a time: it pops when the response register is empty or
// is being drained in that cycle, reads the page table memory, then decides.
// Unmap, write and error responses are registered from the decide state; a read
// first passes through the frame memory read state. Map zeroes the new frame
// one byte a cycle through the single frame memory write port before the entry
// is recorded, and the next request waits for that walk. Frame contents need no
// clearing at reset, since a page becomes readable only after its frame was
// zeroed by map. Mapped and frame-used bits are flops cleared by reset; no
// request is held off after reset.
module paged_memory_with_frame_allocator_top (
  input logic        clk,
  input logic        rst_n,
  pmfa_req_if.sink   in_req,
  pmfa_rsp_if.source out_rsp
);
  pmfa_pkg::cmd_slot_t q_push;
  pmfa_pkg::cmd_slot_t q_head;
  logic                q_full;
  logic                q_pop;

  // Classify and push requests.
  pmfa_front u_front (
    .in_req(in_req),
    .q_full(q_full),
    .q_push(q_push)
  );

  // Decouple front and back.
  pmfa_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .pop(q_pop),
    .full(q_full),
    .head(q_head)
  );

  // Execute requests and hold the response.
  pmfa_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .head(q_head),
    .pop(q_pop),
    .out_rsp(out_rsp)
  );
endmodule

// ===== src/pmfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pmfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/pmfa_front.sv =====
// Front end: accept requests, range-check them and form table indexes.
module pmfa_front (
  pmfa_req_if.sink             in_req,
  input  logic                 q_full,
  output pmfa_pkg::cmd_slot_t  q_push
);
  logic [pmfa_pkg::VPAGE_W-1:0] addr_page;
  logic [pmfa_pkg::VPAGE_W-1:0] sel_page;
  logic                         space_bad;
  logic                         page_bad;
  logic                         addr_bad;
  pmfa_pkg::op_t                op;

  assign in_req.ready = !q_full;
  assign op           = pmfa_pkg::op_t'(in_req.req_type);
  assign addr_page    = pmfa_pkg::VPAGE_W'(in_req.byte_addr >> pmfa_pkg::OFFS_W);
  assign space_bad    = 32'(in_req.space_id) >= pmfa_pkg::SPACE_COUNT;
  assign page_bad     = 32'(in_req.page_num) >= pmfa_pkg::PAGES_PER_SPACE;
  assign addr_bad     = 32'(in_req.byte_addr) >= pmfa_pkg::ADDR_LIMIT;

  always_comb begin
    sel_page = (op == pmfa_pkg::OP_MAP || op == pmfa_pkg::OP_UNMAP)
             ? in_req.page_num : addr_page;
    q_push.valid         = in_req.valid && !q_full;
    q_push.cmd.op        = op;
    q_push.cmd.range_err = space_bad ||
                           (((op == pmfa_pkg::OP_MAP) || (op == pmfa_pkg::OP_UNMAP))
                            ? page_bad : addr_bad);
    q_push.cmd.entry     = pmfa_pkg::ENTRY_W'(32'(in_req.space_id) * pmfa_pkg::PAGES_PER_SPACE
                                             + 32'(sel_page));
    q_push.cmd.offset    = pmfa_pkg::OFFS_W'(in_req.byte_addr);
    q_push.cmd.writable  = in_req.page_writable;
    q_push.cmd.data      = in_req.write_data;
  end
endmodule

// ===== src/pmfa_queue.sv =====
// Two-entry queue of classified requests between front and back.
module pmfa_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  pmfa_pkg::cmd_slot_t push,
  input  logic                pop,
  output logic                full,
  output pmfa_pkg::cmd_slot_t head
);
  pmfa_pkg::cmd_t slot_r [2];
  logic           wptr_r, wptr_nxt;
  logic           rptr_r, rptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign full       = count_r == 2'd2;
  assign head.valid = count_r != 2'd0;
  assign head.cmd   = slot_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push.valid) begin
      wptr_nxt = !wptr_r;
    end
    if (pop) begin
      rptr_nxt = !rptr_r;
    end
    count_nxt = count_r + 2'(push.valid) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
    if (push.valid) begin
      slot_r[wptr_r] <= push.cmd;
    end
  end
endmodule

// ===== src/pmfa_back.sv =====
// Back end: page table lookup, frame allocation, zeroing walk and byte access.
module pmfa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pmfa_pkg::cmd_slot_t head,
  output logic                pop,
  pmfa_rsp_if.source          out_rsp
);
  pmfa_pkg::bk_state_t state_r, state_nxt;
  pmfa_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [pmfa_pkg::OFFS_W-1:0]  cnt_r, cnt_nxt;
  logic [pmfa_pkg::FRAME_W-1:0] frame_r, frame_nxt;
  logic [pmfa_pkg::ENTRY_COUNT-1:0] mapped_r, mapped_nxt;
  logic [pmfa_pkg::FRAME_COUNT-1:0] in_use_r, in_use_nxt;
  logic                out_valid_r, out_valid_nxt;
  pmfa_pkg::status_t   status_r, status_nxt;
  logic [pmfa_pkg::DATA_W-1:0] rdata_r, rdata_nxt;

  pmfa_pkg::entry_t    ent_rd;
  pmfa_pkg::entry_t    ent_wdata;
  logic                ent_we;
  logic                byte_we;
  logic [pmfa_pkg::BYTE_W-1:0] byte_waddr, byte_raddr, ent_pos;
  logic [pmfa_pkg::DATA_W-1:0] byte_wdata, byte_rd;

  logic                free_found;
  logic [pmfa_pkg::FRAME_W-1:0] free_idx;
  pmfa_pkg::status_t   dec_status;
  logic                dec_zero;
  logic                dec_read;
  logic                zero_last;
  logic                cur_mapped;

  pmfa_ram #(.WIDTH($bits(pmfa_pkg::entry_t)), .DEPTH(pmfa_pkg::ENTRY_COUNT)) u_entry_ram (
    .clk(clk), .we(ent_we), .waddr(cmd_r.entry), .wdata(ent_wdata),
    .raddr(head.cmd.entry), .rdata(ent_rd)
  );

  pmfa_ram #(.WIDTH(pmfa_pkg::DATA_W), .DEPTH(pmfa_pkg::BYTE_COUNT)) u_frame_ram (
    .clk(clk), .we(byte_we), .waddr(byte_waddr), .wdata(byte_wdata),
    .raddr(byte_raddr), .rdata(byte_rd)
  );

  assign cur_mapped = mapped_r[cmd_r.entry];
  assign ent_pos    = pmfa_pkg::BYTE_W'(32'(ent_rd.frame) * pmfa_pkg::PAGE_BYTES
                                        + 32'(cmd_r.offset));
  assign zero_last  = cnt_r == pmfa_pkg::OFFS_W'(pmfa_pkg::PAGE_BYTES - 1);
  // Take the next request once the response register is empty or drains this cycle.
  assign pop        = (state_r == pmfa_pkg::BK_IDLE) && head.valid &&
                      (!out_valid_r || out_rsp.ready);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = pmfa_pkg::FRAME_COUNT - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = pmfa_pkg::FRAME_W'(i);
      end
    end
  end

  // Classify the looked-up request: range, mapping, free frame, consistency, permission.
  always_comb begin
    dec_status = pmfa_pkg::ST_OK;
    dec_zero   = 1'b0;
    dec_read   = 1'b0;
    if (cmd_r.range_err) begin
      dec_status = pmfa_pkg::ST_RANGE;
    end else begin
      case (cmd_r.op)
        pmfa_pkg::OP_MAP: begin
          if (cur_mapped) begin
            dec_status = pmfa_pkg::ST_EXISTS;
          end else if (!free_found) begin
            dec_status = pmfa_pkg::ST_FULL;
          end else begin
            dec_zero = 1'b1;
          end
        end
        default: begin
          if (!cur_mapped) begin
            dec_status = pmfa_pkg::ST_NOT_MAPPED;
          end else if (!in_use_r[ent_rd.frame]) begin
            dec_status = pmfa_pkg::ST_INCONSISTENT;
          end else if (cmd_r.op == pmfa_pkg::OP_READ) begin
            dec_read = 1'b1;
          end else if (cmd_r.op == pmfa_pkg::OP_WRITE && !ent_rd.can_write) begin
            dec_status = pmfa_pkg::ST_NOT_WRITABLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pmfa_pkg::BK_IDLE: begin
        if (pop) begin
          state_nxt = pmfa_pkg::BK_DECIDE;
        end
      end
      pmfa_pkg::BK_DECIDE: begin
        if (dec_zero) begin
          state_nxt = pmfa_pkg::BK_ZERO;
        end else if (dec_read) begin
          state_nxt = pmfa_pkg::BK_FRAME_RD;
        end else begin
          state_nxt = pmfa_pkg::BK_IDLE;
        end
      end
      pmfa_pkg::BK_ZERO: begin
        if (zero_last) begin
          state_nxt = pmfa_pkg::BK_IDLE;
        end
      end
      pmfa_pkg::BK_FRAME_RD: state_nxt = pmfa_pkg::BK_IDLE;
      default: state_nxt = pmfa_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    frame_nxt     = frame_r;
    mapped_nxt    = mapped_r;
    in_use_nxt    = in_use_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    status_nxt    = status_r;
    rdata_nxt     = rdata_r;
    ent_we        = 1'b0;
    ent_wdata     = '{can_write: cmd_r.writable, frame: frame_r};
    byte_we       = 1'b0;
    byte_waddr    = pmfa_pkg::BYTE_W'(32'(frame_r) * pmfa_pkg::PAGE_BYTES + 32'(cnt_r));
    byte_wdata    = '0;
    byte_raddr    = ent_pos;
    case (state_r)
      pmfa_pkg::BK_IDLE: begin
        if (pop) begin
          cmd_nxt = head.cmd;
        end
      end
      pmfa_pkg::BK_DECIDE: begin
        cnt_nxt   = '0;
        frame_nxt = free_idx;
        if (!dec_zero && !dec_read) begin
          out_valid_nxt = 1'b1;
          status_nxt    = dec_status;
          rdata_nxt     = '0;
          if (dec_status == pmfa_pkg::ST_OK && cmd_r.op == pmfa_pkg::OP_UNMAP) begin
            mapped_nxt[cmd_r.entry] = 1'b0;
            in_use_nxt[ent_rd.frame] = 1'b0;
          end
          if (dec_status == pmfa_pkg::ST_OK && cmd_r.op == pmfa_pkg::OP_WRITE) begin
            byte_we    = 1'b1;
            byte_waddr = ent_pos;
            byte_wdata = cmd_r.data;
          end
        end
      end
      pmfa_pkg::BK_ZERO: begin
        byte_we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (zero_last) begin
          ent_we                  = 1'b1;
          mapped_nxt[cmd_r.entry] = 1'b1;
          in_use_nxt[frame_r]     = 1'b1;
          out_valid_nxt           = 1'b1;
          status_nxt              = pmfa_pkg::ST_OK;
          rdata_nxt               = '0;
        end
      end
      pmfa_pkg::BK_FRAME_RD: begin
        out_valid_nxt = 1'b1;
        status_nxt    = pmfa_pkg::ST_OK;
        rdata_nxt     = byte_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pmfa_pkg::BK_IDLE;
      mapped_r    <= '0;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mapped_r    <= mapped_nxt;
      in_use_r    <= in_use_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r    <= cmd_nxt;
    cnt_r    <= cnt_nxt;
    frame_r  <= frame_nxt;
    status_r <= status_nxt;
    rdata_r  <= rdata_nxt;
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = status_r;
  assign out_rsp.read_data = rdata_r;
endmodule

// ===== src/pmfa_checker.sv =====
// Port-level checker of the paged memory block and its bind.
`include "paged_memory_with_frame_allocator_top_assert.svh"

module pmfa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pmfa_pkg::STATUS_W-1:0] status,
  input logic [pmfa_pkg::DATA_W-1:0]   read_data
);
  `PMFA_ASSERT_AFTER_RESET(a_out_empty_after_reset, !out_valid)
  `PMFA_ASSERT_AFTER_RESET(a_in_ready_after_reset, in_ready)
  `PMFA_ASSERT_IMPLY(a_rdata_zero_on_error, out_valid && status != pmfa_pkg::ST_OK, read_data == '0)
  `PMFA_ASSERT_NEXT(a_out_held_on_stall, out_valid && !out_ready, out_valid)
endmodule

bind paged_memory_with_frame_allocator_top pmfa_checker u_pmfa_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_req.ready),
  .out_valid(out_rsp.valid),
  .out_ready(out_rsp.ready),
  .status(out_rsp.status),
  .read_data(out_rsp.read_data)
);
